// ===== hw/rtl/sra_pkg.sv =====
// ---------------------------------------------------------------------------
// sra_pkg
// Shared types and codes for the sparse row accumulator: request codes,
// channel payloads, controller states and memory control signals.
// ---------------------------------------------------------------------------
package sra_pkg;

    localparam logic [1:0] REQ_ACC   = 2'd0;
    localparam logic [1:0] REQ_NEWROW = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [9:0]         col;
        logic signed [31:0] a_val;
        logic signed [31:0] b_val;
    } sra_req_t;

    typedef struct packed {
        logic [9:0]         out_col;
        logic signed [63:0] out_value;
        logic [10:0]        row_count;
        logic               last;
        logic               empty_res;
    } sra_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_MUL,
        ST_ACC_WR,
        ST_DR_LIST,
        ST_DR_VAL
    } sra_state_t;

    typedef struct packed {
        logic tag_re;
        logic tag_we;
        logic val_re;
        logic val_we;
        logic list_re;
        logic list_we;
    } sra_mem_ctl_t;

endpackage

// ===== hw/rtl/sparse_row_accumulator_unit.sv =====
// ---------------------------------------------------------------------------
// sparse_row_accumulator_unit
// Row-wise sparse accumulator for Gustavson sparse matrix multiplication.
// ---------------------------------------------------------------------------
// Requests arrive on the s_ channel (valid/ready); drain results leave on the
// m_ channel through an output register, so new requests are taken while a
// result waits for m_ready. Only drain requests produce a result.
// One request is in work at a time. Steps per request:
//   accumulate: tag/value read, multiply, write back,
//   new row:    counter reset and epoch step,
//   drain:      list read, value read, result load; an empty drain only loads.
// A drain result becomes visible on m_valid the cycle after it is loaded,
// and the drain holds the controller while the output register is full
// and m_ready is low. Reset starts a clearing pass that zeroes every epoch
// tag; s_ready stays low until it finishes. The same pass runs whenever the
// epoch counter wraps, once every 2**(EPOCH_BITS-1) new-row requests.
// A column is current in a row when its tag equals epoch+1; the epoch steps
// by two, so a cleared tag never matches.
// ---------------------------------------------------------------------------
module sparse_row_accumulator_unit #(
    parameter int COLUMNS    = 1024,
    parameter int EPOCH_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sra_pkg::sra_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sra_pkg::sra_res_t m_data
);

    localparam int IDX_W = $clog2(COLUMNS);
    localparam int CNT_W = $clog2(COLUMNS + 1);
    localparam int CX_W  = IDX_W + 10;
    localparam int RX_W  = CNT_W + 11;

    sra_pkg::sra_state_t   state_reg, state_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic                  hit_reg, hit_next;
    logic                  m_valid_reg, m_valid_next;

    logic [IDX_W-1:0]      idx_reg;
    logic signed [31:0]    a_reg, b_reg;
    logic signed [63:0]    prod_reg;
    sra_pkg::sra_res_t     m_data_reg;

    sra_pkg::sra_mem_ctl_t ctl;
    logic [IDX_W-1:0]      tag_raddr, tag_waddr, val_raddr, list_raddr, list_waddr;
    logic [EPOCH_BITS-1:0] tag_wdata, tag_rdata;
    logic [63:0]           val_wdata, val_rdata;
    logic [IDX_W-1:0]      list_rdata;

    logic                  accept, out_free, out_load, col_ok, first_touch, ovf;
    logic [CX_W-1:0]       col_x, list_x;
    logic [RX_W-1:0]       count_x;
    logic [EPOCH_BITS-1:0] cur_tag;
    logic [EPOCH_BITS:0]   epoch_step;
    logic [63:0]           sum;
    sra_pkg::sra_res_t     res;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign col_x    = CX_W'(s_data.col);
    assign list_x   = CX_W'(list_rdata);
    assign count_x  = RX_W'(count_reg);
    assign col_ok   = 32'(s_data.col) < 32'(COLUMNS);
    assign cur_tag  = epoch_reg + EPOCH_BITS'(1);
    assign epoch_step = {1'b0, epoch_reg} + (EPOCH_BITS + 1)'(2);

    // Saturating 64-bit add of the stored sum and the new product.
    assign sum = val_rdata + prod_reg;
    assign ovf = (val_rdata[63] == prod_reg[63]) && (sum[63] != val_rdata[63]);
    assign first_touch = tag_rdata != cur_tag;

    always_comb begin
        res = '0;
        res.row_count = count_x[10:0];
        if (hit_reg) begin
            res.out_col   = list_x[9:0];
            res.out_value = val_rdata;
            res.last      = (ptr_reg + CNT_W'(1)) == count_reg;
        end else begin
            res.empty_res = 1'b1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        epoch_next   = epoch_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        clr_idx_next = clr_idx_reg;
        hit_next     = hit_reg;
        out_load     = 1'b0;
        s_ready      = 1'b0;
        ctl          = '0;
        tag_raddr    = col_x[IDX_W-1:0];
        tag_waddr    = idx_reg;
        tag_wdata    = cur_tag;
        val_raddr    = col_x[IDX_W-1:0];
        val_wdata    = prod_reg;
        list_raddr   = ptr_reg[IDX_W-1:0];
        list_waddr   = count_reg[IDX_W-1:0];

        unique case (state_reg)
            sra_pkg::ST_CLEAR: begin
                ctl.tag_we = 1'b1;
                tag_waddr  = clr_idx_reg;
                tag_wdata  = '0;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(COLUMNS - 1)) begin
                    clr_idx_next = '0;
                    state_next   = sra_pkg::ST_IDLE;
                end
            end
            sra_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.req_type)
                        sra_pkg::REQ_ACC: begin
                            if (col_ok) begin
                                ctl.tag_re = 1'b1;
                                ctl.val_re = 1'b1;
                                state_next = sra_pkg::ST_ACC_MUL;
                            end
                        end
                        sra_pkg::REQ_NEWROW: begin
                            count_next = '0;
                            ptr_next   = '0;
                            if (epoch_step[EPOCH_BITS]) begin
                                epoch_next = '0;
                                state_next = sra_pkg::ST_CLEAR;
                            end else begin
                                epoch_next = epoch_step[EPOCH_BITS-1:0];
                            end
                        end
                        sra_pkg::REQ_DRAIN: begin
                            if (ptr_reg < count_reg) begin
                                ctl.list_re = 1'b1;
                                hit_next    = 1'b1;
                                state_next  = sra_pkg::ST_DR_LIST;
                            end else begin
                                hit_next   = 1'b0;
                                state_next = sra_pkg::ST_DR_VAL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sra_pkg::ST_ACC_MUL: begin
                state_next = sra_pkg::ST_ACC_WR;
            end
            sra_pkg::ST_ACC_WR: begin
                ctl.val_we = 1'b1;
                if (first_touch) begin
                    ctl.tag_we = 1'b1;
                    if (count_reg < CNT_W'(COLUMNS)) begin
                        ctl.list_we = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end else if (ovf) begin
                    val_wdata = val_rdata[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    val_wdata = sum;
                end
                state_next = sra_pkg::ST_IDLE;
            end
            sra_pkg::ST_DR_LIST: begin
                ctl.val_re = 1'b1;
                val_raddr  = list_rdata;
                state_next = sra_pkg::ST_DR_VAL;
            end
            sra_pkg::ST_DR_VAL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (hit_reg) begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                    state_next = sra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sra_pkg::ST_IDLE;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sra_pkg::ST_CLEAR;
            epoch_reg   <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            clr_idx_reg <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            epoch_reg   <= epoch_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            clr_idx_reg <= clr_idx_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg <= col_x[IDX_W-1:0];
            a_reg   <= s_data.a_val;
            b_reg   <= s_data.b_val;
        end
        if (state_reg == sra_pkg::ST_ACC_MUL) begin
            prod_reg <= a_reg * b_reg;
        end
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    sra_mem #(
        .COLUMNS    (COLUMNS),
        .EPOCH_BITS (EPOCH_BITS)
    ) u_mem (
        .aclk       (aclk),
        .ctl        (ctl),
        .tag_raddr  (tag_raddr),
        .tag_waddr  (tag_waddr),
        .tag_wdata  (tag_wdata),
        .tag_rdata  (tag_rdata),
        .val_raddr  (val_raddr),
        .val_waddr  (idx_reg),
        .val_wdata  (val_wdata),
        .val_rdata  (val_rdata),
        .list_raddr (list_raddr),
        .list_waddr (list_waddr),
        .list_wdata (idx_reg),
        .list_rdata (list_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The drain pointer never passes the number of touched columns.
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ptr_reg <= count_reg) && (count_reg <= CNT_W'(COLUMNS)))
        else $error("drain pointer or touched count out of range");

    // The epoch stays even so that a cleared tag is never current.
    a_epoch_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !epoch_reg[0])
        else $error("epoch became odd");

    // Value and list memories are never written during a clearing pass.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sra_pkg::ST_CLEAR) |-> !ctl.val_we && !ctl.list_we)
        else $error("value or list write during tag clearing");

    // A loaded non-empty drain item advances the pointer by exactly one.
    a_ptr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && hit_reg) |=> (ptr_reg == $past(ptr_reg) + CNT_W'(1)))
        else $error("drain pointer did not advance");

    // A loaded result is shown on the next cycle.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("loaded result not presented");

endmodule

// ===== hw/rtl/sra_mem.sv =====
// ---------------------------------------------------------------------------
// sra_mem
// The three column memories of the accumulator: epoch tags, accumulated
// values and the touched-column list. Each has one write port and one read
// port with a registered, enable-gated read.
// ---------------------------------------------------------------------------
module sra_mem #(
    parameter int COLUMNS    = 1024,
    parameter int EPOCH_BITS = 16
) (
    input  logic                         aclk,
    input  sra_pkg::sra_mem_ctl_t        ctl,
    input  logic [$clog2(COLUMNS)-1:0]   tag_raddr,
    input  logic [$clog2(COLUMNS)-1:0]   tag_waddr,
    input  logic [EPOCH_BITS-1:0]        tag_wdata,
    output logic [EPOCH_BITS-1:0]        tag_rdata,
    input  logic [$clog2(COLUMNS)-1:0]   val_raddr,
    input  logic [$clog2(COLUMNS)-1:0]   val_waddr,
    input  logic [63:0]                  val_wdata,
    output logic [63:0]                  val_rdata,
    input  logic [$clog2(COLUMNS)-1:0]   list_raddr,
    input  logic [$clog2(COLUMNS)-1:0]   list_waddr,
    input  logic [$clog2(COLUMNS)-1:0]   list_wdata,
    output logic [$clog2(COLUMNS)-1:0]   list_rdata
);

    localparam int IDX_W = $clog2(COLUMNS);

    logic [EPOCH_BITS-1:0] tag_mem  [COLUMNS];
    logic [63:0]           val_mem  [COLUMNS];
    logic [IDX_W-1:0]      list_mem [COLUMNS];

    always_ff @(posedge aclk) begin
        if (ctl.tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (ctl.tag_re) begin
            tag_rdata <= tag_mem[tag_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (ctl.val_re) begin
            val_rdata <= val_mem[val_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (ctl.list_re) begin
            list_rdata <= list_mem[list_raddr];
        end
    end

endmodule

// ===== tb/sv/tb_sparse_row_accumulator_unit.sv =====
// ---------------------------------------------------------------------------
// tb_sparse_row_accumulator_unit
// Self-checking bench for the row-wise sparse accumulator. Request items are
// driven from a backlog queue and scored against an in-bench model of the
// tag, value and touched-list stores. A narrow epoch makes wraps frequent.
// ---------------------------------------------------------------------------
module tb_sparse_row_accumulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         COLS         = 1024;
    localparam int         EPOCH_W      = 4;
    localparam int         RANDOM_ITEMS = 850;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sra_pkg::sra_req_t s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sra_pkg::sra_res_t m_data;

    sparse_row_accumulator_unit #(
        .COLUMNS    (COLS),
        .EPOCH_BITS (EPOCH_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the accumulator state.
    logic [EPOCH_W-1:0] col_tag     [COLS];
    logic [63:0]        col_sum     [COLS];
    logic [9:0]         touch_order [COLS];
    int unsigned        row_epoch = 0;
    int unsigned        touched   = 0;
    int unsigned        drained   = 0;

    sra_pkg::sra_req_t req_backlog[$];
    sra_pkg::sra_res_t drain_results_due[$];
    int       total_items  = 0;
    int       items_sent   = 0;
    int       random_count = 0;
    int       mismatches   = 0;
    bit       req_accepted = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("** sparse_row_accumulator_unit: FAILED **");
        $finish;
    end

    task automatic step_row_accumulator(input sra_pkg::sra_req_t r);
        longint             a;
        longint             b;
        logic [63:0]        prod;
        logic [63:0]        sum;
        logic [EPOCH_W-1:0] live_tag;
        sra_pkg::sra_res_t  res;
        a        = $signed(r.a_val);
        b        = $signed(r.b_val);
        prod     = a * b;
        live_tag = EPOCH_W'(row_epoch + 1);
        case (r.req_type)
            sra_pkg::REQ_ACC: begin
                if (col_tag[r.col] != live_tag) begin
                    col_tag[r.col] = live_tag;
                    col_sum[r.col] = prod;
                    if (touched < COLS) begin
                        touch_order[touched] = r.col;
                        touched++;
                    end
                end else begin
                    sum = col_sum[r.col] + prod;
                    if (col_sum[r.col][63] == prod[63] && sum[63] != prod[63]) begin
                        sum = prod[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    end
                    col_sum[r.col] = sum;
                end
            end
            sra_pkg::REQ_NEWROW: begin
                // Stepping past the top of the epoch range clears every tag.
                if (row_epoch + 2 > (1 << EPOCH_W) - 1) begin
                    row_epoch = 0;
                    foreach (col_tag[i]) col_tag[i] = '0;
                end else begin
                    row_epoch += 2;
                end
                touched = 0;
                drained = 0;
            end
            sra_pkg::REQ_DRAIN: begin
                res           = '0;
                res.row_count = 11'(touched);
                if (drained < touched) begin
                    res.out_col   = touch_order[drained];
                    res.out_value = col_sum[touch_order[drained]];
                    res.last      = (drained + 1 == touched);
                    drained++;
                end else begin
                    res.empty_res = 1'b1;
                end
                drain_results_due.push_back(res);
            end
            REQ_UNUSED: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Scoreboard: requests are modeled as they are accepted, results are
    // checked in order against the oldest outstanding drain.
    always @(posedge aclk) begin
        sra_pkg::sra_res_t want;
        req_accepted = aresetn && s_valid && s_ready;
        if (req_accepted) begin
            step_row_accumulator(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            if (drain_results_due.size() == 0) begin
                flag_mismatch("result with no drain outstanding", 64'd0, m_data.out_value);
            end else begin
                want = drain_results_due.pop_front();
                if (m_data.out_col !== want.out_col)
                    flag_mismatch("out_col", 64'(want.out_col), 64'(m_data.out_col));
                if (m_data.out_value !== want.out_value)
                    flag_mismatch("out_value", want.out_value, m_data.out_value);
                if (m_data.row_count !== want.row_count)
                    flag_mismatch("row_count", 64'(want.row_count), 64'(m_data.row_count));
                if (m_data.last !== want.last)
                    flag_mismatch("last", 64'(want.last), 64'(m_data.last));
                if (m_data.empty_res !== want.empty_res)
                    flag_mismatch("empty_res", 64'(want.empty_res), 64'(m_data.empty_res));
            end
        end
    end

    // Driver and result-side throttle, both updated on the falling edge.
    always @(negedge aclk) begin
        int phase;
        int idle_pct;
        int stall_pct;
        phase = (total_items == 0) ? 0 : items_sent * 3 / total_items;
        case (phase)
            0:       begin idle_pct = 20; stall_pct = 86; end
            1:       begin idle_pct = 86; stall_pct = 20; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && (!s_valid || req_accepted)) begin
            if (req_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                s_data  <= req_backlog.pop_front();
                s_valid <= 1'b1;
                items_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic queue_req(input logic [1:0] kind, input int c,
                             input logic [31:0] a, input logic [31:0] b);
        sra_pkg::sra_req_t r;
        r.req_type = kind;
        r.col      = 10'(c);
        r.a_val    = a;
        r.b_val    = b;
        req_backlog.push_back(r);
        if (kind != REQ_UNUSED) random_count++;
    endtask

    function automatic logic [31:0] pick_operand();
        int mag;
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5, 6: return $urandom();
            default: begin
                // Modest Q16.16 values, roughly within plus or minus 16.
                mag = $urandom_range(0, 1 << 20);
                return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
            end
        endcase
    endfunction

    initial begin
        int          n_acc;
        int          n_pool;
        int          n_drain;
        int          mid_drains;
        int          c;
        bit          heavy;
        bit          neg;
        int          pool [8];
        bit          seen [int];
        logic [31:0] a;
        logic [31:0] b;

        foreach (col_tag[i]) col_tag[i] = '0;

        // Directed: empty drain, negative saturation, an ignored code,
        // accumulation during a drain, stale tags and an epoch wrap.
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        queue_req(sra_pkg::REQ_ACC,    0,    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_req(sra_pkg::REQ_ACC,    0,    32'h8000_0000, 32'h8000_0000);
        queue_req(sra_pkg::REQ_ACC,    1023, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(sra_pkg::REQ_ACC,    1023, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(sra_pkg::REQ_ACC,    1023, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(sra_pkg::REQ_ACC,    0,    32'hFFFF_FFFF, 32'h0000_0001);
        queue_req(REQ_UNUSED,          5,    32'h1234_5678, 32'h9ABC_DEF0);
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        queue_req(sra_pkg::REQ_ACC,    512,  32'h0,         32'hFFFF_FFFF);
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        queue_req(sra_pkg::REQ_NEWROW, 0,    32'h0,         32'h0);
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        queue_req(sra_pkg::REQ_ACC,    0,    32'h0001_0000, 32'h0001_0000);
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        repeat (7) queue_req(sra_pkg::REQ_NEWROW, 0, 32'h0, 32'h0);
        queue_req(sra_pkg::REQ_ACC,    1023, 32'h0002_0000, 32'h0003_0000);
        queue_req(sra_pkg::REQ_DRAIN,  0,    32'h0,         32'h0);
        random_count = 0;

        while (random_count < RANDOM_ITEMS) begin
            n_acc  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 12);
            n_pool = $urandom_range(1, 8);
            heavy  = ($urandom_range(0, 6) == 0);
            neg    = 1'($urandom_range(0, 1));
            foreach (pool[i]) pool[i] = $urandom_range(0, COLS - 1);
            seen.delete();
            mid_drains = 0;
            // Now and then a row is left open and simply continued.
            if ($urandom_range(0, 19) != 0) begin
                queue_req(sra_pkg::REQ_NEWROW, 0, 32'h0, 32'h0);
            end
            repeat (n_acc) begin
                c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COLS - 1)
                                                : pool[$urandom_range(0, n_pool - 1)];
                if (heavy) begin
                    // Large products of one sign drive the sums into saturation.
                    a = 32'h7FFF_0000 | $urandom_range(0, 16'hFFFF);
                    b = neg ? (32'h8000_0000 | $urandom_range(0, 16'hFFFF))
                            : (32'h7FFF_0000 | $urandom_range(0, 16'hFFFF));
                end else begin
                    a = pick_operand();
                    b = pick_operand();
                end
                queue_req(sra_pkg::REQ_ACC, c, a, b);
                seen[c] = 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    queue_req(sra_pkg::REQ_DRAIN, $urandom_range(0, COLS - 1),
                              $urandom(), $urandom());
                    mid_drains++;
                end
                if ($urandom_range(0, 39) == 0) begin
                    queue_req(REQ_UNUSED, $urandom_range(0, COLS - 1), $urandom(), $urandom());
                end
            end
            n_drain = seen.num() - mid_drains;
            if (n_drain < 0) n_drain = 0;
            n_drain += $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) n_drain = $urandom_range(0, n_drain);
            repeat (n_drain) begin
                queue_req(sra_pkg::REQ_DRAIN, $urandom_range(0, COLS - 1),
                          $urandom(), $urandom());
            end
        end
        total_items = req_backlog.size();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() > 0 || s_valid) @(posedge aclk);
        while (drain_results_due.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (mismatches == 0) begin
            $display("** sparse_row_accumulator_unit: PASSED **");
        end else begin
            $display("** sparse_row_accumulator_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sra_pkg.sv
hw/rtl/sra_mem.sv
hw/rtl/sparse_row_accumulator_unit.sv
tb/sv/tb_sparse_row_accumulator_unit.sv
